/* design/srs_pkg.sv */
// srs_pkg: shared types and constants of the slot reservation scheduler
// no dependencies
`timescale 1ns / 1ps
package srs_pkg;
  localparam int unsigned TableDepth = 16;
  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam int unsigned HandleW = 4;
  localparam int unsigned HandleCount = 16;
  localparam int unsigned CfgW = 24;

  localparam logic [1:0] CmdInsert = 2'd0;
  localparam logic [1:0] CmdRemove = 2'd1;
  localparam logic [1:0] CmdFind   = 2'd2;
  localparam logic [1:0] CmdCheck  = 2'd3;

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusFull  = 2'd1;
  localparam logic [1:0] StatusNoHdl = 2'd2;

  localparam logic [1:0] CfgGuard  = 2'd0;
  localparam logic [1:0] CfgGap    = 2'd1;
  localparam logic [1:0] CfgWindow = 2'd2;

  typedef struct packed {
    logic [31:0]        begin_t;
    logic [31:0]        end_t;
    logic               rx;
    logic [HandleW-1:0] handle;
  } entry_t;
endpackage

/* design/srs_table_ram.sv */
// srs_table_ram: slot table storage, one write and one read port
// depends on srs_pkg for the entry layout
`timescale 1ns / 1ps
module srs_table_ram (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [srs_pkg::IdxW-1:0] waddr_i,
  input  srs_pkg::entry_t      wdata_i,
  input  logic [srs_pkg::IdxW-1:0] raddr_i,
  output srs_pkg::entry_t      rdata_o
);
  import srs_pkg::*;
  entry_t mem [TableDepth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

/* design/slot_reservation_scheduler_core.sv */
// slot_reservation_scheduler_core: top level of the slot reservation scheduler
// depends on srs_pkg and srs_table_ram
`timescale 1ns / 1ps
// sorted slot table in a one-port-read synchronous ram. one command at a time:
// each command walks the table one entry per read. find and check first pop every
// expired leading entry; insert and remove shift entries with a read-then-write
// pair per entry, and an insert into a full table answers without a walk. the
// result waits in an output register; the next command may be taken while it
// waits and finishes once the result has been handed off.
// slave tdata (low bit up): command[1:0], begin_time[31:0], end_time[31:0],
// is_receive_slot, slot_handle[3:0], earliest_time[31:0], slot_length[31:0],
// is_data_packet, jitter_fraction[7:0], now_time[31:0], 176 bits, no padding.
// master tdata: status[1:0], assigned_handle[3:0], start_time[31:0], is_free,
// padded to 40 bits. config regs: 0 guard, 1 data gap, 2 jitter window.
module slot_reservation_scheduler_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [175:0] s_axis_tdata,  // command, begin, end, rx, handle, earliest,
                                      // length, data, jitter, now
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [39:0]  m_axis_tdata,  // status, handle, start_time, is_free
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [srs_pkg::CfgW-1:0] cfg_data_i
);
  import srs_pkg::*;

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StExpRd  = 4'd1;  // read entry 0 for expiry
  localparam logic [3:0] StExpChk = 4'd2;
  localparam logic [3:0] StShDnRd = 4'd3;  // shift toward front
  localparam logic [3:0] StShDnWr = 4'd4;
  localparam logic [3:0] StWalkRd = 4'd5;  // walk for find/check/insert/remove
  localparam logic [3:0] StWalk   = 4'd6;
  localparam logic [3:0] StShUpRd = 4'd7;  // shift toward back for insert
  localparam logic [3:0] StShUpWr = 4'd8;
  localparam logic [3:0] StDone   = 4'd9;

  logic [3:0] st_q, st_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [HandleCount-1:0] used_q, used_d;
  logic [CfgW-1:0] guard_q, gap_q, win_q;

  // latched command
  logic [1:0]  cmd_q;
  logic [31:0] bin_q, ein_q, now_q;
  logic        rxin_q, data_q;
  logic [3:0]  hsel_q;
  logic [7:0]  frac_q;
  logic [1:0]  cmd_d;
  logic [31:0] bin_d, ein_d, now_d;
  logic        rxin_d, data_d;
  logic [3:0]  hsel_d;
  logic [7:0]  frac_d;

  logic [CntW-1:0] pos_q, pos_d;       // walk index / shift cursor
  logic [CntW-1:0] stop_q, stop_d;     // insert position
  logic            exp_q, exp_d;       // removal is an expiry pop
  logic [31:0] lower_q, lower_d;
  logic [33:0] need_q, need_d;
  logic        clash_q, clash_d;
  logic [3:0]  newh_q, newh_d;
  logic [1:0]  wst_q, wst_d;           // status of the command in work
  logic [3:0]  wh_q, wh_d;             // handle of the command in work

  logic        ovalid_q, ovalid_d;
  logic [1:0]  ost_q, ost_d;
  logic [3:0]  oh_q, oh_d;
  logic [31:0] ostart_q, ostart_d;
  logic        ofree_q, ofree_d;

  logic        we;
  logic [IdxW-1:0] waddr, raddr;
  entry_t      wdata, rdata;

  srs_table_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // lowest free handle
  logic [3:0] freeh;
  logic       anyfree;
  always_comb begin
    freeh = '0;
    anyfree = 1'b0;
    for (int i = HandleCount - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        freeh = 4'(i);
        anyfree = 1'b1;
      end
    end
  end

  // jitter product: window * fraction, registered path via lower add at done
  logic [31:0] jit;
  logic [33:0] res_sum;
  logic signed [33:0] chk_lo, chk_hi, sb, se;
  assign jit = data_q ? 32'd0 : 32'((({8'd0, win_q} * {24'd0, frac_q})) >> 8);
  assign res_sum = {2'b0, lower_q} + {2'b0, jit};
  assign chk_lo = $signed({2'b0, bin_q}) - $signed({10'd0, guard_q});
  assign chk_hi = $signed({2'b0, ein_q}) + $signed({10'd0, guard_q});
  assign sb = $signed({2'b0, rdata.begin_t});
  assign se = $signed({2'b0, rdata.end_t});

  // a waiting result does not block the next command
  assign s_axis_tready = (st_q == StIdle);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {1'b0, ofree_q, ostart_q, oh_q, ost_q};

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; used_d = used_q;
    cmd_d = cmd_q; bin_d = bin_q; ein_d = ein_q;
    now_d = now_q; rxin_d = rxin_q; data_d = data_q; hsel_d = hsel_q; frac_d = frac_q;
    pos_d = pos_q; stop_d = stop_q; exp_d = exp_q; lower_d = lower_q;
    need_d = need_q; clash_d = clash_q; newh_d = newh_q;
    wst_d = wst_q; wh_d = wh_q;
    ovalid_d = ovalid_q; ost_d = ost_q; oh_d = oh_q; ostart_d = ostart_q;
    ofree_d = ofree_q;
    we = 1'b0; waddr = '0; wdata = '0; raddr = pos_q[IdxW-1:0];
    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;
    unique case (st_q)
      StIdle: begin
        if (s_axis_tvalid && s_axis_tready) begin
          cmd_d  = s_axis_tdata[1:0];
          bin_d  = s_axis_tdata[33:2];
          ein_d  = s_axis_tdata[65:34];
          rxin_d = s_axis_tdata[66];
          hsel_d = s_axis_tdata[70:67];
          data_d = s_axis_tdata[135];
          frac_d = s_axis_tdata[143:136];
          now_d  = s_axis_tdata[175:144];
          pos_d = '0; clash_d = 1'b0; exp_d = 1'b0;
          lower_d = s_axis_tdata[102:71];
          wst_d = StatusOk; wh_d = '0;
          priority case (s_axis_tdata[1:0])
            CmdInsert: begin
              if (cnt_q >= CntW'(TableDepth) || !anyfree) begin
                wst_d = StatusFull; st_d = StDone;
              end else begin
                newh_d = freeh; st_d = StWalkRd;
              end
            end
            CmdRemove: st_d = StWalkRd;
            default:   st_d = StExpRd;
          endcase
          if (s_axis_tdata[135])
            need_d = {2'b0, s_axis_tdata[134:103]} + {10'd0, gap_q};
          else
            need_d = {2'b0, s_axis_tdata[134:103]} + {10'd0, guard_q}
                     + {10'd0, win_q};
        end
      end
      StExpRd: begin
        raddr = '0;
        if (cnt_q == '0) begin
          pos_d = '0; st_d = StWalkRd;
        end else st_d = StExpChk;
      end
      StExpChk: begin
        if ({1'b0, rdata.end_t} + {9'd0, guard_q} < {1'b0, now_q}) begin
          used_d[rdata.handle] = 1'b0;
          exp_d = 1'b1; pos_d = '0; st_d = StShDnRd;
        end else begin
          pos_d = '0; st_d = StWalkRd;
        end
      end
      StShDnRd: begin
        // move entry pos+1 to pos
        if (pos_q + 1'b1 >= cnt_q) begin
          cnt_d = cnt_q - 1'b1;
          st_d = exp_q ? StExpRd : StDone;
        end else begin
          raddr = IdxW'(pos_q + 1'b1);
          st_d = StShDnWr;
        end
      end
      StShDnWr: begin
        we = 1'b1; waddr = pos_q[IdxW-1:0]; wdata = rdata;
        pos_d = pos_q + 1'b1; st_d = StShDnRd;
      end
      StWalkRd: begin
        if (pos_q >= cnt_q) begin
          // walk reached the end
          priority case (cmd_q)
            CmdInsert: begin stop_d = pos_q; pos_d = cnt_q; st_d = StShUpRd; end
            CmdRemove: begin wst_d = StatusNoHdl; st_d = StDone; end
            default:   st_d = StDone;
          endcase
        end else st_d = StWalk;
      end
      StWalk: begin
        st_d = StWalkRd; pos_d = pos_q + 1'b1;
        priority case (cmd_q)
          CmdInsert: begin
            if (rdata.begin_t > bin_q) begin
              stop_d = pos_q; pos_d = cnt_q; st_d = StShUpRd;
            end
          end
          CmdRemove: begin
            if (rdata.handle == hsel_q) begin
              used_d[rdata.handle] = 1'b0; exp_d = 1'b0; st_d = StShDnRd;
              pos_d = pos_q;
            end
          end
          CmdFind: begin
            if (!rdata.rx) begin
              if (rdata.begin_t > lower_q &&
                  {2'b0, rdata.begin_t - lower_q} > need_q) begin
                st_d = StDone;
              end else if (rdata.end_t > lower_q) begin
                lower_d = rdata.end_t;
              end
            end
          end
          default: begin
            if ((chk_lo < sb && chk_hi > sb) || (chk_lo < se && chk_hi > se)) begin
              clash_d = 1'b1; st_d = StDone;
            end
          end
        endcase
      end
      StShUpRd: begin
        // move entry pos-1 to pos, then place new entry at stop
        if (pos_q == stop_q) begin
          we = 1'b1; waddr = stop_q[IdxW-1:0];
          wdata = '{begin_t: bin_q, end_t: ein_q, rx: rxin_q, handle: newh_q};
          cnt_d = cnt_q + 1'b1; used_d[newh_q] = 1'b1; wh_d = newh_q;
          st_d = StDone;
        end else begin
          raddr = IdxW'(pos_q - 1'b1);
          st_d = StShUpWr;
        end
      end
      StShUpWr: begin
        we = 1'b1; waddr = pos_q[IdxW-1:0]; wdata = rdata;
        pos_d = pos_q - 1'b1; st_d = StShUpRd;
      end
      StDone: begin
        // wait here while the previous result is still held
        if (!ovalid_q) begin
          ost_d = wst_q; oh_d = wh_q;
          ostart_d = '0;
          ofree_d = 1'b0;
          if (cmd_q == CmdFind)
            ostart_d = res_sum[33:32] != 2'b0 ? 32'hFFFF_FFFF : res_sum[31:0];
          if (cmd_q == CmdCheck) ofree_d = !clash_q;
          ovalid_d = 1'b1; st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; cnt_q <= '0; used_q <= '0; ovalid_q <= 1'b0;
      guard_q <= '0; gap_q <= '0; win_q <= CfgW'(100000);
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; used_q <= used_d; ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgGuard:  guard_q <= cfg_data_i;
          CfgGap:    gap_q <= cfg_data_i;
          CfgWindow: win_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; bin_q <= bin_d; ein_q <= ein_d;
    now_q <= now_d; rxin_q <= rxin_d; data_q <= data_d;
    hsel_q <= hsel_d; frac_q <= frac_d; pos_q <= pos_d; stop_q <= stop_d;
    exp_q <= exp_d; lower_q <= lower_d; need_q <= need_d; clash_q <= clash_d;
    newh_q <= newh_d; wst_q <= wst_d; wh_q <= wh_d; ost_q <= ost_d; oh_q <= oh_d;
    ostart_q <= ostart_d; ofree_q <= ofree_d;
  end
endmodule

/* tb/sv/tb_top.sv */
// tb_top: self-checking testbench of slot_reservation_scheduler_core
// depends on srs_pkg and the scheduler rtl; predicts every result item and compares
`timescale 1ns / 1ps
module tb_top;
  import srs_pkg::*;

  // one command item as the block sees it
  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] begin_t;
    logic [31:0] end_t;
    logic        rx;
    logic [3:0]  hsel;
    logic [31:0] earliest;
    logic [31:0] length;
    logic        data;
    logic [7:0]  frac;
    logic [31:0] now;
  } cmd_item_t;

  // one result item
  typedef struct {
    logic [1:0]  status;
    logic [3:0]  handle;
    logic [31:0] start_t;
    logic        is_free;
  } reply_t;

  // directed row: command plus an optional typed-in answer
  typedef struct {
    cmd_item_t c;
    bit        fixed;
    reply_t    r;
  } dir_row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [175:0] s_axis_tdata;   // command, begin, end, rx, handle, earliest,
                                // length, data, jitter, now
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [39:0]  m_axis_tdata;   // status, handle, start_time, is_free
  logic         cfg_we_i;
  logic [1:0]   cfg_idx_i;
  logic [CfgW-1:0] cfg_data_i;

  slot_reservation_scheduler_core i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------
  // shadow of the slot table and registers
  // ---------------------------------------------------------------
  logic [31:0] tbl_begin [TableDepth];
  logic [31:0] tbl_end   [TableDepth];
  logic        tbl_rx    [TableDepth];
  logic [3:0]  tbl_hdl   [TableDepth];
  int unsigned tbl_cnt;
  logic [15:0] hdl_busy;
  logic [23:0] guard_us, gap_us, window_us;

  // expected result items in order of acceptance
  reply_t      reply_fifo [16];
  int unsigned rf_wr, rf_rd, rf_cnt;
  int unsigned fail_cnt;
  bit          rx_hold;       // forces the receiver to stall
  bit          rx_no_idle;    // last part of the run: no stalls
  bit          tx_no_idle;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
    fail_cnt++;
  endtask

  task automatic reply_put(input reply_t r);
    reply_fifo[rf_wr] = r;
    rf_wr = (rf_wr + 1) % 16;
    rf_cnt++;
  endtask

  function automatic logic [38:0] pack_reply(input reply_t r);
    return {r.is_free, r.start_t, r.handle, r.status};
  endfunction

  function automatic void drop_slot(input int unsigned pos);
    hdl_busy[tbl_hdl[pos]] = 1'b0;
    for (int unsigned i = pos; i + 1 < tbl_cnt; i++) begin
      tbl_begin[i] = tbl_begin[i+1];
      tbl_end[i]   = tbl_end[i+1];
      tbl_rx[i]    = tbl_rx[i+1];
      tbl_hdl[i]   = tbl_hdl[i+1];
    end
    tbl_cnt--;
  endfunction

  // leading slots whose end plus guard lies before now are gone
  function automatic void expire_slots(input logic [31:0] now);
    while (tbl_cnt > 0 && {32'd0, tbl_end[0]} + {40'd0, guard_us} < {32'd0, now})
      drop_slot(0);
  endfunction

  function automatic reply_t schedule_cmd(input cmd_item_t c);
    reply_t r;
    int unsigned h, pos;
    logic [63:0] gap, win, need, res;
    logic [31:0] lower;
    longint lo, hi, sb, se;
    bit clash;
    r = '{default: '0};
    case (c.cmd)
      CmdInsert: begin
        h = HandleCount;
        for (int unsigned i = 0; i < HandleCount; i++)
          if (!hdl_busy[i] && h == HandleCount) h = i;
        if (tbl_cnt >= TableDepth || h >= HandleCount) begin
          r.status = StatusFull;
        end else begin
          pos = 0;
          while (pos < tbl_cnt && tbl_begin[pos] <= c.begin_t) pos++;
          for (int unsigned i = tbl_cnt; i > pos; i--) begin
            tbl_begin[i] = tbl_begin[i-1];
            tbl_end[i]   = tbl_end[i-1];
            tbl_rx[i]    = tbl_rx[i-1];
            tbl_hdl[i]   = tbl_hdl[i-1];
          end
          tbl_begin[pos] = c.begin_t;
          tbl_end[pos]   = c.end_t;
          tbl_rx[pos]    = c.rx;
          tbl_hdl[pos]   = h[3:0];
          tbl_cnt++;
          hdl_busy[h] = 1'b1;
          r.handle = h[3:0];
        end
      end
      CmdRemove: begin
        pos = tbl_cnt;
        for (int unsigned i = 0; i < tbl_cnt; i++)
          if (tbl_hdl[i] == c.hsel && pos == tbl_cnt) pos = i;
        if (pos >= tbl_cnt) r.status = StatusNoHdl;
        else drop_slot(pos);
      end
      CmdFind: begin
        gap   = c.data ? {40'd0, gap_us} : {40'd0, guard_us};
        win   = c.data ? 64'd0 : {40'd0, window_us};
        need  = {32'd0, c.length} + gap + win;
        lower = c.earliest;
        expire_slots(c.now);
        for (int unsigned i = 0; i < tbl_cnt; i++) begin
          if (tbl_rx[i]) continue;
          if (tbl_begin[i] > lower && {32'd0, tbl_begin[i] - lower} > need) break;
          if (tbl_end[i] > lower) lower = tbl_end[i];
        end
        res = {32'd0, lower} + ((win * {56'd0, c.frac}) >> 8);
        r.start_t = (res > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : res[31:0];
      end
      default: begin
        lo = longint'({32'd0, c.begin_t}) - longint'({40'd0, guard_us});
        hi = longint'({32'd0, c.end_t}) + longint'({40'd0, guard_us});
        clash = 1'b0;
        expire_slots(c.now);
        for (int unsigned i = 0; i < tbl_cnt; i++) begin
          sb = longint'({32'd0, tbl_begin[i]});
          se = longint'({32'd0, tbl_end[i]});
          if ((lo < sb && hi > sb) || (lo < se && hi > se)) clash = 1'b1;
        end
        r.is_free = !clash;
      end
    endcase
    return r;
  endfunction

  function automatic logic [175:0] pack_cmd(input cmd_item_t c);
    return {c.now, c.frac, c.data, c.length, c.earliest, c.hsel, c.rx,
            c.end_t, c.begin_t, c.cmd};
  endfunction

  // ---------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------
  task automatic send_cmd(input cmd_item_t c, input bit fixed, input reply_t fixed_r);
    reply_t r;
    int unsigned gap;
    bit ready_seen;
    if (!tx_no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_cmd(c);
    // ready only moves at the rising edge, so the mid-cycle value holds at the edge
    do begin
      @(negedge clk_i);
      ready_seen = s_axis_tready;
      @(posedge clk_i);
    end while (!ready_seen);
    // accepted at this edge: predict now, in order of acceptance
    r = schedule_cmd(c);
    if (fixed) begin
      if (pack_reply(r) != pack_reply(fixed_r))
        report("directed answer", {25'd0, pack_reply(r)}, {25'd0, pack_reply(fixed_r)});
      r = fixed_r;
    end
    reply_put(r);
  endtask

  task automatic drain_replies();
    s_axis_tvalid <= 1'b0;
    while (rf_cnt != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CfgGuard: guard_us  = val;
      CfgGap:   gap_us    = val;
      default:  window_us = val;
    endcase
  endtask

  // time values clustered near a base so that slots overlap often
  function automatic logic [31:0] near_t(input logic [31:0] base);
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return 32'hFFFF_FFFF - $urandom_range(0, 1000);
      2:       return $urandom_range(0, 50);
      default: return base + $urandom_range(0, 20000);
    endcase
  endfunction

  function automatic cmd_item_t rand_cmd(input logic [31:0] base);
    cmd_item_t c;
    int unsigned sel;
    c.begin_t  = near_t(base);
    c.end_t    = ($urandom_range(0, 15) == 0) ? near_t(base) :
                 c.begin_t + $urandom_range(0, 5000);
    c.rx       = 1'($urandom_range(0, 1));
    c.earliest = near_t(base);
    c.length   = ($urandom_range(0, 15) == 0) ? $urandom() : $urandom_range(0, 4000);
    c.data     = 1'($urandom_range(0, 1));
    c.frac     = 8'($urandom_range(0, 255));
    c.now      = ($urandom_range(0, 3) == 0) ? near_t(base) : base;
    // remove mostly targets live handles
    c.hsel     = 4'($urandom_range(0, 15));
    if (tbl_cnt != 0 && $urandom_range(0, 3) != 0)
      c.hsel = tbl_hdl[$urandom_range(0, tbl_cnt - 1)];
    sel = $urandom_range(0, 99);
    // keep the table busy: inserts lead, then finds and checks
    if (sel < 35)      c.cmd = CmdInsert;
    else if (sel < 55) c.cmd = CmdRemove;
    else if (sel < 80) c.cmd = CmdFind;
    else               c.cmd = CmdCheck;
    return c;
  endfunction

  // ---------------------------------------------------------------
  // receiver side: random stalls, forced hold, then checking
  // ---------------------------------------------------------------
  initial begin : rx_side
    int unsigned stall;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (rx_hold) begin
        m_axis_tready <= 1'b0;
        @(posedge clk_i);
      end else if (!rx_no_idle && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 9);
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // valid, ready and data only move at the rising edge: a handshake seen
  // mid-cycle is the one taken at the next edge
  always @(negedge clk_i) begin : reply_check
    reply_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (rf_cnt == 0) begin
        report("unexpected result item", {24'd0, m_axis_tdata}, 64'd0);
      end else begin
        exp_r = reply_fifo[rf_rd];
        rf_rd = (rf_rd + 1) % 16;
        rf_cnt--;
        if (m_axis_tdata[1:0] !== exp_r.status)
          report("status", m_axis_tdata[1:0], exp_r.status);
        if (m_axis_tdata[5:2] !== exp_r.handle)
          report("assigned_handle", m_axis_tdata[5:2], exp_r.handle);
        if (m_axis_tdata[37:6] !== exp_r.start_t)
          report("start_time", m_axis_tdata[37:6], exp_r.start_t);
        if (m_axis_tdata[38] !== exp_r.is_free)
          report("is_free", m_axis_tdata[38], exp_r.is_free);
      end
    end
  end

  // hold-off counted in cycles in its own process
  task automatic hold_receiver(input int unsigned cycles);
    rx_hold = 1'b1;
    repeat (cycles) @(posedge clk_i);
    rx_hold = 1'b0;
  endtask

  // ---------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------
  localparam logic [31:0] T0 = 32'd1_000_000;
  reply_t      ok_r;
  dir_row_t    dir_rows [32];
  int unsigned dir_n;

  task automatic add_row(input dir_row_t row);
    dir_rows[dir_n] = row;
    dir_n++;
  endtask

  function automatic cmd_item_t mk(input logic [1:0] cmd, input logic [31:0] b,
                                   input logic [31:0] e, input logic rx,
                                   input logic [3:0] h, input logic [31:0] now);
    cmd_item_t c;
    c = '{cmd: cmd, begin_t: b, end_t: e, rx: rx, hsel: h, earliest: b,
          length: e - b, data: rx, frac: 8'hFF, now: now};
    return c;
  endfunction

  initial begin : stim
    cmd_item_t c;
    logic [31:0] base;
    int unsigned phase;
    fail_cnt      = 0;
    rf_wr         = 0;
    rf_rd         = 0;
    rf_cnt        = 0;
    dir_n         = 0;
    ok_r          = '{default: '0};
    rx_hold       = 1'b0;
    rx_no_idle    = 1'b0;
    tx_no_idle    = 1'b0;
    tbl_cnt       = 0;
    hdl_busy      = '0;
    guard_us      = '0;
    gap_us        = '0;
    window_us     = 24'd100000;
    rst_ni        = 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CfgGuard;
    cfg_data_i    <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part with reset register values
    // remove on an empty table: unknown handle
    add_row('{mk(CmdRemove, 32'd0, 32'd0, 1'b0, 4'hF, 32'd0), 1'b1,
              '{StatusNoHdl, 4'd0, 32'd0, 1'b0}});
    // find on empty table: earliest + window*255/256
    add_row('{mk(CmdFind, 32'd0, 32'd0, 1'b0, 4'd0, 32'd0), 1'b1,
              '{StatusOk, 4'd0, 32'd99609, 1'b0}});
    // find saturates at the top of the time range
    add_row('{mk(CmdFind, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 4'd0, 32'd0), 1'b1,
              '{StatusOk, 4'd0, 32'hFFFF_FFFF, 1'b0}});
    // empty table is free
    add_row('{mk(CmdCheck, 32'hFFFF_FFFF, 32'd0, 1'b0, 4'd0, 32'd0), 1'b1,
              '{StatusOk, 4'd0, 32'd0, 1'b1}});
    // fill all sixteen handles, reversed slots and extremes included
    for (int i = 0; i < 16; i++)
      add_row('{mk(CmdInsert, (i == 0) ? 32'hFFFF_FFFF : T0 - 32'(i * 1000),
                   (i == 1) ? 32'd0 : T0 - 32'(i * 1000) + 32'd500, i[0],
                   4'd0, 32'd0), 1'b1, '{StatusOk, i[3:0], 32'd0, 1'b0}});
    // table full
    add_row('{mk(CmdInsert, T0, T0 + 32'd1, 1'b0, 4'd0, 32'd0), 1'b1,
              '{StatusFull, 4'd0, 32'd0, 1'b0}});
    add_row('{mk(CmdRemove, 32'd0, 32'd0, 1'b0, 4'd7, 32'd0), 1'b1, '{default: '0}});
    add_row('{mk(CmdRemove, 32'd0, 32'd0, 1'b0, 4'd7, 32'd0), 1'b1,
              '{StatusNoHdl, 4'd0, 32'd0, 1'b0}});
    add_row('{mk(CmdCheck, T0 - 32'd5200, T0 - 32'd4800, 1'b0, 4'd0, 32'd0), 1'b0,
              '{default: '0}});
    add_row('{mk(CmdFind, T0 - 32'd20000, T0 - 32'd19000, 1'b1, 4'd0, 32'd0), 1'b0,
              '{default: '0}});
    // expiry by now sweeps the table
    add_row('{mk(CmdCheck, 32'd0, 32'd10, 1'b0, 4'd0, 32'hFFFF_FFFF), 1'b0,
              '{default: '0}});
    for (int unsigned i = 0; i < dir_n; i++)
      send_cmd(dir_rows[i].c, dir_rows[i].fixed, dir_rows[i].r);
    drain_replies();

    // random phases over several register settings, extremes among them
    base = T0;
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin write_reg(CfgGuard, '0); write_reg(CfgGap, '0); write_reg(CfgWindow, '0); end
        1: begin write_reg(CfgGuard, 24'hFF_FFFF); write_reg(CfgGap, 24'hFF_FFFF);
                 write_reg(CfgWindow, 24'hFF_FFFF); end
        default: begin
          write_reg(CfgGuard, 24'($urandom_range(0, 3000)));
          write_reg(CfgGap, 24'($urandom_range(0, 3000)));
          write_reg(CfgWindow, ($urandom_range(0, 3) == 0) ? 24'($urandom()) :
                                                            24'($urandom_range(0, 5000)));
        end
      endcase
      if (phase == 7) begin
        rx_no_idle = 1'b1;
        tx_no_idle = 1'b1;
      end
      for (int n = 0; n < 195; n++) begin
        if (n == 60 && phase == 3) begin
          // long receiver hold while commands keep coming
          fork
            hold_receiver(400);
          join_none
        end
        if (n == 120 && phase == 4) begin
          // sender waits for every outstanding result
          s_axis_tvalid <= 1'b0;
          do @(posedge clk_i); while (rf_cnt != 0);
        end
        c = rand_cmd(base);
        base += $urandom_range(0, 400);
        send_cmd(c, 1'b0, ok_r);
      end
      drain_replies();
    end

    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

/* filelist.f */
design/srs_pkg.sv
design/srs_table_ram.sv
design/slot_reservation_scheduler_core.sv
tb/sv/tb_top.sv
